// File: design/three_phase_svpwm_duty_defines.svh
// assertion macros for the three-phase svpwm duty block
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef THREE_PHASE_SVPWM_DUTY_DEFINES_SVH
`define THREE_PHASE_SVPWM_DUTY_DEFINES_SVH

// same-cycle implication
`define SVPWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define SVPWM_ASSERT_LAT(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// File: design/svpwm_pkg.sv
// shared constants and types for the three-phase svpwm duty block
// no dependencies
package svpwm_pkg;

  localparam int FIELD_W             = 16;
  localparam int PHASES              = 3;
  localparam int RATIO_FRAC_BITS_DEF = 15;
  // phase voltages are q8.24, signed, and their midpoint offsets fit in 35 bits
  localparam int DV_W                = 35;
  localparam int MAG_W               = 34;
  // bus voltage q8.8 times 2^17 gives the q8.24 divisor
  localparam int BUS_SHIFT           = 17;
  // overflow test: |dv| >= bus * 2^18 means the ratio magnitude is 2 or more
  localparam int OVF_SHIFT           = 18;

  localparam logic signed [17:0]        SQRT3_HALF_Q16 = 18'sd56756;
  localparam logic [FIELD_W-1:0]        WRAP_RESET     = 16'd4095;

  typedef struct packed {
    logic valid;
    logic bus_zero;
    logic neg;
    logic ovf;
  } phase_ctl_t;

  typedef struct packed {
    logic valid;
    logic bus_zero;
    logic sat;
  } scale_st_t;

endpackage

// File: design/svpwm_front.sv
// inverse clarke, min-max injection offset and magnitude/sign split
// depends on svpwm_pkg
module svpwm_front import svpwm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [FIELD_W-1:0] v_alpha_i,
  input  logic signed [FIELD_W-1:0] v_beta_i,
  input  logic        [FIELD_W-1:0] bus_voltage_i,
  output phase_ctl_t                ctl_o [PHASES],
  output logic        [MAG_W-1:0]   mag_o [PHASES],
  output logic        [FIELD_W-1:0] bus_o
);

  // valid bits of stages 1..6
  logic [5:0] v_q;

  logic signed [FIELD_W-1:0] alpha1_q, beta1_q, alpha2_q;
  logic        [FIELD_W-1:0] bus1_q, bus2_q, bus3_q, bus4_q, bus5_q, bus6_q;
  logic signed [33:0]        prod_d, prod2_q;
  logic signed [DV_W-1:0]    ext_a, ext_p, va_d, vb_d, vc_d;
  logic signed [DV_W-1:0]    v3_q [PHASES];
  logic signed [DV_W-1:0]    v4_q [PHASES];
  logic signed [DV_W-1:0]    vmax, vmin, sum_d, sum4_q;
  logic signed [DV_W-1:0]    dv_d [PHASES];
  logic signed [DV_W-1:0]    dv5_q [PHASES];
  logic        [MAG_W-1:0]   ovf_lim;
  logic        [DV_W-1:0]    abs_full [PHASES];
  logic        [MAG_W-1:0]   mag_d [PHASES];
  logic        [MAG_W-1:0]   mag6_q [PHASES];
  logic        [PHASES-1:0]  neg6_q, ovf6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], start_i};
    end
  end

  // stage 2: sqrt(3)/2 * beta
  assign prod_d = SQRT3_HALF_Q16 * beta1_q;

  // stage 3: phase voltages
  always_comb begin
    ext_a = DV_W'(alpha2_q);
    ext_p = DV_W'(prod2_q);
    va_d  = ext_a <<< 16;
    vb_d  = ext_p - (ext_a <<< 15);
    vc_d  = -ext_p - (ext_a <<< 15);
  end

  // stage 4: max + min of the three phases
  always_comb begin
    vmax = (v3_q[0] > v3_q[1]) ? v3_q[0] : v3_q[1];
    vmax = (vmax > v3_q[2]) ? vmax : v3_q[2];
    vmin = (v3_q[0] < v3_q[1]) ? v3_q[0] : v3_q[1];
    vmin = (vmin < v3_q[2]) ? vmin : v3_q[2];
    sum_d = vmax + vmin;
  end

  // stage 5: 2v - (max + min)
  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      dv_d[p] = (v4_q[p] <<< 1) - sum4_q;
    end
  end

  // stage 6: magnitude, sign and ratio overflow
  assign ovf_lim = MAG_W'({bus5_q, {OVF_SHIFT{1'b0}}});
  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      abs_full[p] = dv5_q[p][DV_W-1] ? DV_W'(-dv5_q[p]) : DV_W'(dv5_q[p]);
      mag_d[p]    = abs_full[p][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    alpha1_q <= v_alpha_i;
    beta1_q  <= v_beta_i;
    bus1_q   <= bus_voltage_i;

    alpha2_q <= alpha1_q;
    prod2_q  <= prod_d;
    bus2_q   <= bus1_q;

    v3_q[0]  <= va_d;
    v3_q[1]  <= vb_d;
    v3_q[2]  <= vc_d;
    bus3_q   <= bus2_q;

    v4_q     <= v3_q;
    sum4_q   <= sum_d;
    bus4_q   <= bus3_q;

    dv5_q    <= dv_d;
    bus5_q   <= bus4_q;

    for (int p = 0; p < PHASES; p++) begin
      mag6_q[p] <= mag_d[p];
      neg6_q[p] <= dv5_q[p][DV_W-1];
      ovf6_q[p] <= mag_d[p] >= ovf_lim;
    end
    bus6_q   <= bus5_q;
  end

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      ctl_o[p].valid    = v_q[5];
      ctl_o[p].bus_zero = (bus6_q == '0);
      ctl_o[p].neg      = neg6_q[p];
      ctl_o[p].ovf      = ovf6_q[p];
      mag_o[p]          = mag6_q[p];
    end
  end

  assign bus_o = bus6_q;

endmodule

// File: design/svpwm_div.sv
// pipelined restoring divider, one quotient bit per stage, for one phase
// depends on svpwm_pkg
module svpwm_div import svpwm_pkg::*; #(
  parameter int FracBits = RATIO_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  phase_ctl_t         ctl_i,
  input  logic [MAG_W-1:0]   mag_i,
  input  logic [FIELD_W-1:0] bus_i,
  output phase_ctl_t         ctl_o,
  output logic [FracBits:0]  quo_o
);

  localparam int QW = FracBits + 1;
  localparam int NW = MAG_W + FracBits;

  phase_ctl_t         ctl_q [QW];
  logic [NW-1:0]      rem_q [QW];
  logic [QW-1:0]      quo_q [QW];
  logic [FIELD_W-1:0] bus_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;

    phase_ctl_t         ctl_in;
    logic [NW-1:0]      rem_in, dsh, rem_d;
    logic [QW-1:0]      quo_in, quo_d;
    logic [FIELD_W-1:0] bus_in;
    logic               ge;

    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rem_in = NW'(mag_i) << FracBits;
      assign quo_in = '0;
      assign bus_in = bus_i;
    end else begin : g_rest
      assign ctl_in = ctl_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign bus_in = bus_q[s-1];
    end

    // divisor bus * 2^17 aligned to quotient bit B
    assign dsh = NW'(bus_in) << (B + BUS_SHIFT);
    assign ge  = rem_in >= dsh;

    always_comb begin
      rem_d    = ge ? (rem_in - dsh) : rem_in;
      quo_d    = quo_in;
      quo_d[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      quo_q[s] <= quo_d;
      bus_q[s] <= bus_in;
    end
  end

  assign ctl_o = ctl_q[QW-1];
  assign quo_o = quo_q[QW-1];

endmodule

// File: design/svpwm_scale.sv
// duty offset, clamp and scaling by the pwm wrap for one phase
// depends on svpwm_pkg
module svpwm_scale import svpwm_pkg::*; #(
  parameter int FracBits = RATIO_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  phase_ctl_t         ctl_i,
  input  logic [FracBits:0]  quo_i,
  input  logic [FIELD_W-1:0] wrap_i,
  output scale_st_t          st_o,
  output logic [FIELD_W-1:0] duty_o
);

  localparam int QW = FracBits + 1;
  localparam int PW = FIELD_W + QW;

  logic [QW-1:0]      half, t_d, t_q;
  logic               over, hi_d, lo_d, hi_q, lo_q;
  logic [1:0]         v_q;
  logic               bz1_q;
  scale_st_t          st_d, st_q;
  logic [PW-1:0]      prod;
  logic [FIELD_W-1:0] duty_d, duty_q;

  // stage 1: t = half +/- quotient, clamp detection
  always_comb begin
    half = QW'(1) << (FracBits - 1);
    over = ctl_i.ovf || (quo_i > half);
    t_d  = ctl_i.neg ? (half - quo_i) : (half + quo_i);
    hi_d = !ctl_i.neg && over;
    lo_d = ctl_i.neg && over;
  end

  // stage 2: wrap * t / 2^frac, or wrap/2, wrap or 0 on bus zero, high or low clamp
  always_comb begin
    prod = PW'(wrap_i) * PW'(t_q);
    if (bz1_q) begin
      duty_d = wrap_i >> 1;
    end else if (hi_q) begin
      duty_d = wrap_i;
    end else if (lo_q) begin
      duty_d = '0;
    end else begin
      duty_d = prod[FracBits +: FIELD_W];
    end
    st_d.valid    = v_q[0];
    st_d.bus_zero = bz1_q;
    st_d.sat      = !bz1_q && (hi_q || lo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    bz1_q  <= ctl_i.bus_zero;
    st_q   <= st_d;
    duty_q <= duty_d;
  end

  // valid travels in v_q; the registered copy in st_q follows it
  always_comb begin
    st_o       = st_q;
    st_o.valid = v_q[1] & st_q.valid;
  end
  assign duty_o = duty_q;

endmodule

// File: design/three_phase_svpwm_duty.sv
// 6 front, RATIO_FRAC_BITS + 1 divider and 2 scaling stages lie between start_i and done_o
// throughput: one item per cycle, busy_o stays low; the per-phase divider pipeline, one
// quotient bit per stage, sets the depth
// reset: rst_ni low clears the front, divider and scaling valid shift bits and loads the wrap register with 4095
// the receiver cannot stall; each result is shown for exactly one cycle
module three_phase_svpwm_duty import svpwm_pkg::*; #(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [FIELD_W-1:0] v_alpha_i,
  input  logic signed [FIELD_W-1:0] v_beta_i,
  input  logic        [FIELD_W-1:0] bus_voltage_i,
  input  logic                      cfg_we_i,
  input  logic        [FIELD_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output logic        [FIELD_W-1:0] duty_a_o,
  output logic        [FIELD_W-1:0] duty_b_o,
  output logic        [FIELD_W-1:0] duty_c_o,
  output logic                      saturated_o,
  output logic                      bus_error_o
);

`include "three_phase_svpwm_duty_defines.svh"

  localparam int LAT = RATIO_FRAC_BITS + 9;

  logic [FIELD_W-1:0]         wrap_q;
  phase_ctl_t                 front_ctl [PHASES];
  logic [MAG_W-1:0]           front_mag [PHASES];
  logic [FIELD_W-1:0]         front_bus;
  phase_ctl_t                 div_ctl [PHASES];
  logic [RATIO_FRAC_BITS:0]   div_quo [PHASES];
  scale_st_t                  sc_st [PHASES];
  logic [FIELD_W-1:0]         sc_duty [PHASES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= WRAP_RESET;
    end else if (cfg_we_i) begin
      wrap_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  svpwm_front u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .v_alpha_i,
    .v_beta_i,
    .bus_voltage_i,
    .ctl_o (front_ctl),
    .mag_o (front_mag),
    .bus_o (front_bus)
  );

  for (genvar p = 0; p < PHASES; p++) begin : g_phase
    svpwm_div #(.FracBits(RATIO_FRAC_BITS)) u_div (
      .clk_i,
      .rst_ni,
      .ctl_i (front_ctl[p]),
      .mag_i (front_mag[p]),
      .bus_i (front_bus),
      .ctl_o (div_ctl[p]),
      .quo_o (div_quo[p])
    );

    svpwm_scale #(.FracBits(RATIO_FRAC_BITS)) u_scale (
      .clk_i,
      .rst_ni,
      .ctl_i  (div_ctl[p]),
      .quo_i  (div_quo[p]),
      .wrap_i (wrap_q),
      .st_o   (sc_st[p]),
      .duty_o (sc_duty[p])
    );
  end

  assign done_o      = sc_st[0].valid;
  assign duty_a_o    = sc_duty[0];
  assign duty_b_o    = sc_duty[1];
  assign duty_c_o    = sc_duty[2];
  assign saturated_o = sc_st[0].sat | sc_st[1].sat | sc_st[2].sat;
  assign bus_error_o = sc_st[0].bus_zero;

  `SVPWM_ASSERT_LAT(a_latency, start_i && !busy_o, LAT, done_o, "result strobe missing")
  `SVPWM_ASSERT_NOW(a_err_neutral, done_o && bus_error_o,
    duty_a_o == duty_b_o && duty_b_o == duty_c_o, "bus error duties differ")
  `SVPWM_ASSERT_NOW(a_err_nosat, done_o && bus_error_o, !saturated_o,
    "saturation flagged with bus error")

endmodule

// File: tb/three_phase_svpwm_duty_tb.sv
// testbench for three_phase_svpwm_duty: directed and random voltage commands across wrap values
// a scoreboard class predicts the clamped min-max injection duties and checks each done_o strobe
// depends on svpwm_pkg and the three_phase_svpwm_duty top level
module three_phase_svpwm_duty_tb import svpwm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOLT_WIDTH = 16;
  localparam int FRAC_BITS  = RATIO_FRAC_BITS_DEF;
  localparam int PHASE_ITEMS = 275;

  typedef struct {
    logic [FIELD_W-1:0] duty_a;
    logic [FIELD_W-1:0] duty_b;
    logic [FIELD_W-1:0] duty_c;
    logic               saturated;
    logic               bus_error;
  } duty_set_t;

  class duty_scoreboard;
    duty_set_t          pending_duties[$];
    logic [FIELD_W-1:0] wrap;
    int unsigned        mismatches;

    function new();
      wrap       = WRAP_RESET;
      mismatches = 0;
    endfunction

    // one phase: normalized midpoint offset, clamp, scale to wrap
    function logic [FIELD_W-1:0] phase_level(longint v, longint mid_sum, longint den,
                                             inout logic sat);
      longint one;
      longint lim;
      longint ratio;
      longint t;
      one   = longint'(1) << FRAC_BITS;
      lim   = (longint'(1) << (VOLT_WIDTH - 1 + FRAC_BITS)) - 1;
      ratio = ((2 * v - mid_sum) * one) / den;
      if (ratio > lim) ratio = lim;
      if (ratio < -lim - 1) ratio = -lim - 1;
      t = (one >>> 1) + ratio;
      if (t < 0) begin
        sat = 1'b1;
        return '0;
      end
      if (t > one) begin
        sat = 1'b1;
        return wrap;
      end
      return FIELD_W'((longint'(wrap) * t) >>> FRAC_BITS);
    endfunction

    function void note_command(logic signed [FIELD_W-1:0] alpha,
                               logic signed [FIELD_W-1:0] beta,
                               logic [FIELD_W-1:0] bus);
      duty_set_t d;
      longint    a;
      longint    b;
      longint    va;
      longint    vb;
      longint    vc;
      longint    hi;
      longint    lo;
      longint    den;
      logic      sat;
      a   = alpha;
      b   = beta;
      sat = 1'b0;
      if (bus == 0) begin
        d.duty_a    = wrap >> 1;
        d.duty_b    = wrap >> 1;
        d.duty_c    = wrap >> 1;
        d.saturated = 1'b0;
        d.bus_error = 1'b1;
      end else begin
        // inverse clarke in q8.24
        va  = a * 65536;
        vb  = -a * 32768 + longint'(SQRT3_HALF_Q16) * b;
        vc  = -a * 32768 - longint'(SQRT3_HALF_Q16) * b;
        hi  = va > vb ? va : vb;
        hi  = hi > vc ? hi : vc;
        lo  = va < vb ? va : vb;
        lo  = lo < vc ? lo : vc;
        den = longint'(bus) * (longint'(1) << BUS_SHIFT);
        d.duty_a    = phase_level(va, hi + lo, den, sat);
        d.duty_b    = phase_level(vb, hi + lo, den, sat);
        d.duty_c    = phase_level(vc, hi + lo, den, sat);
        d.saturated = sat;
        d.bus_error = 1'b0;
      end
      pending_duties.push_back(d);
    endfunction

    function void check_duties(duty_set_t got);
      duty_set_t exp;
      if (pending_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected duty result a=%0d b=%0d c=%0d sat=%0b err=%0b",
                   got.duty_a, got.duty_b, got.duty_c, got.saturated, got.bus_error);
        return;
      end
      exp = pending_duties.pop_front();
      if (got.duty_a !== exp.duty_a || got.duty_b !== exp.duty_b ||
          got.duty_c !== exp.duty_c || got.saturated !== exp.saturated ||
          got.bus_error !== exp.bus_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"duty mismatch (wrap %0d): exp a=%0d b=%0d c=%0d sat=%0b err=%0b,",
                    " got a=%0d b=%0d c=%0d sat=%0b err=%0b"},
                   wrap, exp.duty_a, exp.duty_b, exp.duty_c, exp.saturated, exp.bus_error,
                   got.duty_a, got.duty_b, got.duty_c, got.saturated, got.bus_error);
      end
    endfunction
  endclass

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      start_i       = 1'b0;
  logic                      busy_o;
  logic signed [FIELD_W-1:0] v_alpha_i     = '0;
  logic signed [FIELD_W-1:0] v_beta_i      = '0;
  logic        [FIELD_W-1:0] bus_voltage_i = '0;
  logic                      cfg_we_i      = 1'b0;
  logic        [FIELD_W-1:0] cfg_wdata_i   = '0;
  logic                      done_o;
  logic        [FIELD_W-1:0] duty_a_o;
  logic        [FIELD_W-1:0] duty_b_o;
  logic        [FIELD_W-1:0] duty_c_o;
  logic                      saturated_o;
  logic                      bus_error_o;

  duty_scoreboard board = new();
  bit             calm  = 1'b0;

  three_phase_svpwm_duty DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .v_alpha_i     (v_alpha_i),
    .v_beta_i      (v_beta_i),
    .bus_voltage_i (bus_voltage_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .duty_a_o      (duty_a_o),
    .duty_b_o      (duty_b_o),
    .duty_c_o      (duty_c_o),
    .saturated_o   (saturated_o),
    .bus_error_o   (bus_error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sampled at the edge, before any nonblocking update of this step
  always @(posedge clk_i) begin
    duty_set_t got;
    if (rst_ni) begin
      if (cfg_we_i) board.wrap = cfg_wdata_i;
      if (start_i && !busy_o) board.note_command(v_alpha_i, v_beta_i, bus_voltage_i);
      if (done_o) begin
        got.duty_a    = duty_a_o;
        got.duty_b    = duty_b_o;
        got.duty_c    = duty_c_o;
        got.saturated = saturated_o;
        got.bus_error = bus_error_o;
        board.check_duties(got);
      end
    end
  end

  task automatic send_command(input logic signed [FIELD_W-1:0] alpha,
                              input logic signed [FIELD_W-1:0] beta,
                              input logic [FIELD_W-1:0] bus);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    v_alpha_i     <= alpha;
    v_beta_i      <= beta;
    bus_voltage_i <= bus;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_duties();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_duties.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_wrap(input logic [FIELD_W-1:0] value);
    drain_duties();
    repeat (30) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly commands scaled to the bus so the duties sit near the linear limit
  task automatic random_commands(input int count);
    logic [FIELD_W-1:0] bus;
    longint             amp;
    int                 kind;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_command(FIELD_W'($urandom), FIELD_W'($urandom), '0);
      end else if (kind < 28) begin
        send_command(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      end else if (kind < 38) begin
        bus = FIELD_W'($urandom_range(1, 16));
        send_command($signed(16'($urandom_range(0, 64))) - 16'sd32,
                     $signed(16'($urandom_range(0, 64))) - 16'sd32, bus);
      end else begin
        bus = FIELD_W'($urandom_range(1, 65535));
        amp = longint'(bus) * $urandom_range(0, 1300) / 1000;
        if (amp > 32767) amp = 32767;
        send_command(FIELD_W'(longint'($urandom_range(0, 32'(2 * amp))) - amp),
                     FIELD_W'(longint'($urandom_range(0, 32'(2 * amp))) - amp), bus);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands at the reset wrap
    send_command(16'sd0, 16'sd0, 16'd0);
    send_command(16'sd100, -16'sd200, 16'd0);
    send_command(16'sd0, 16'sd0, 16'd1);
    send_command(16'sd0, 16'sd0, 16'd65535);
    send_command(-16'sd32768, -16'sd32768, 16'd1);
    send_command(16'sd32767, 16'sd32767, 16'd1);
    send_command(16'sd32767, -16'sd32768, 16'd65535);
    send_command(-16'sd32768, 16'sd32767, 16'd65535);
    send_command(-16'sd32768, 16'sd0, 16'd65535);
    send_command(16'sd0, 16'sd32767, 16'd65535);
    // duties that land exactly on 0 and on wrap, and some that saturate there
    send_command(16'sd2, 16'sd0, 16'd3);
    send_command(-16'sd2, 16'sd0, 16'd3);
    send_command(16'sd2, 16'sd0, 16'd2);
    send_command(16'sd0, 16'sd4, 16'd5);
    send_command(-16'sd21846, 16'sd21845, 16'd43690);
    send_command(16'sd21845, -16'sd21846, 16'd21845);
    send_command(16'sd1000, 16'sd0, 16'd1000);
    send_command(16'sd0, -16'sd1000, 16'd1000);
    send_command(16'sd1, -16'sd1, 16'd65535);
    send_command(-16'sd1, -16'sd1, 16'd32768);
    random_commands(PHASE_ITEMS - 20);

    write_wrap(16'd1);
    random_commands(PHASE_ITEMS);
    write_wrap(16'd65535);
    random_commands(PHASE_ITEMS);
    write_wrap(16'd0);
    random_commands(PHASE_ITEMS / 2);
    write_wrap(FIELD_W'($urandom_range(2, 65534)));
    random_commands(PHASE_ITEMS);
    write_wrap(FIELD_W'($urandom_range(2, 255)));
    random_commands(PHASE_ITEMS);
    write_wrap(FIELD_W'($urandom_range(2, 65534)));
    random_commands(PHASE_ITEMS / 2);

    drain_duties();
    repeat (40) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("three_phase_svpwm_duty test passed");
    end else begin
      $display("three_phase_svpwm_duty test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("three_phase_svpwm_duty test failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/svpwm_pkg.sv
design/svpwm_front.sv
design/svpwm_div.sv
design/svpwm_scale.sv
design/three_phase_svpwm_duty.sv
tb/three_phase_svpwm_duty_tb.sv
